>>> hw/rtl/i2c_eeprom_byte_access_core_defines.svh
// Assertion macros shared by the checker of the EEPROM byte access core.
// Needs clk and rst in the scope where a macro is used.
`ifndef I2C_EEPROM_BYTE_ACCESS_CORE_DEFINES_SVH
`define I2C_EEPROM_BYTE_ACCESS_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define I2CEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define I2CEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/i2cee_pkg.sv
// Shared types and constants of the I2C EEPROM byte access core.
// No dependencies.
`default_nettype none

package i2cee_pkg;

  // Memory address width kept from a command
  localparam int ADDR_BITS = 15;
  localparam logic [14:0] ADDR_MASK = 15'((32'd1 << ADDR_BITS) - 32'd1);

  // APB register map
  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_DEVICE_ADDRESS   = 3'd0,
    REG_TWO_BYTE_ADDRESS = 3'd1,
    REG_UNIT_TICKS       = 3'd2,
    REG_ACK_POLL_LIMIT   = 3'd3,
    REG_WRITE_WAIT_UNITS = 3'd4,
    REG_FILL_WAIT_UNITS  = 3'd5,
    REG_FILL_COUNT       = 3'd6,
    REG_UNUSED           = 3'd7
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [6:0]  RST_DEVICE_ADDRESS   = 7'd80;
  localparam logic        RST_TWO_BYTE_ADDRESS = 1'b1;
  localparam logic [15:0] RST_UNIT_TICKS       = 16'd72;
  localparam logic [7:0]  RST_ACK_POLL_LIMIT   = 8'd250;
  localparam logic [15:0] RST_WRITE_WAIT_UNITS = 16'd15000;
  localparam logic [15:0] RST_FILL_WAIT_UNITS  = 16'd10000;
  localparam logic [6:0]  RST_FILL_COUNT       = 7'd16;

  // Command codes carried in mode
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_FILL  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic        two_byte_address;
    logic [15:0] unit_ticks;
    logic [7:0]  ack_poll_limit;
    logic [15:0] write_wait_units;
    logic [15:0] fill_wait_units;
    logic [6:0]  fill_count;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_result;
    logic       ack_error;
  } res_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cee_cfg_regs.sv
// APB configuration registers of the I2C EEPROM byte access core.
// Depends on i2cee_pkg.
`default_nettype none

module i2cee_cfg_regs
  import i2cee_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address   <= RST_DEVICE_ADDRESS;
      cfg.two_byte_address <= RST_TWO_BYTE_ADDRESS;
      cfg.unit_ticks       <= RST_UNIT_TICKS;
      cfg.ack_poll_limit   <= RST_ACK_POLL_LIMIT;
      cfg.write_wait_units <= RST_WRITE_WAIT_UNITS;
      cfg.fill_wait_units  <= RST_FILL_WAIT_UNITS;
      cfg.fill_count       <= RST_FILL_COUNT;
    end else if (wr) begin
      unique case (idx)
        REG_DEVICE_ADDRESS:   cfg.device_address   <= pwdata[6:0];
        REG_TWO_BYTE_ADDRESS: cfg.two_byte_address <= pwdata[0];
        REG_UNIT_TICKS:       cfg.unit_ticks       <= pwdata[15:0];
        REG_ACK_POLL_LIMIT:   cfg.ack_poll_limit   <= pwdata[7:0];
        REG_WRITE_WAIT_UNITS: cfg.write_wait_units <= pwdata[15:0];
        REG_FILL_WAIT_UNITS:  cfg.fill_wait_units  <= pwdata[15:0];
        REG_FILL_COUNT:       cfg.fill_count       <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_DEVICE_ADDRESS:   prdata = {25'd0, cfg.device_address};
      REG_TWO_BYTE_ADDRESS: prdata = {31'd0, cfg.two_byte_address};
      REG_UNIT_TICKS:       prdata = {16'd0, cfg.unit_ticks};
      REG_ACK_POLL_LIMIT:   prdata = {24'd0, cfg.ack_poll_limit};
      REG_WRITE_WAIT_UNITS: prdata = {16'd0, cfg.write_wait_units};
      REG_FILL_WAIT_UNITS:  prdata = {16'd0, cfg.fill_wait_units};
      REG_FILL_COUNT:       prdata = {25'd0, cfg.fill_count};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2cee_seq.sv
// Bus sequencer: one step of the I2C frame per accepted transaction.
// Depends on i2cee_pkg; result goes to the output buffer.
`default_nettype none

module i2cee_seq
  import i2cee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        accept,
  input  wire logic [1:0]  mode,
  input  wire logic [14:0] mem_address,
  input  wire logic [7:0]  write_byte,
  input  wire logic        sda_sample,
  output res_t             res
);

  typedef enum logic [3:0] {
    P_IDLE, P_START_A, P_START_B, P_TX_LO1, P_TX_HI, P_TX_LO2,
    P_ACK_REL, P_ACK_HI, P_ACK_POLL, P_RX_LO, P_RX_HI,
    P_NACK_LO, P_NACK_HI, P_STOP_A, P_STOP_B, P_WAIT
  } phase_t;

  typedef enum logic [2:0] {
    S_CTRL_W, S_ADDR_HI, S_ADDR_LO, S_DATA, S_CTRL_R
  } stage_t;

  phase_t      phase, phase_next;
  stage_t      stage, stage_next;
  logic [15:0] unit_counter, unit_counter_next;
  logic [15:0] units_left, units_left_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  poll_counter, poll_counter_next;
  logic [6:0]  bytes_left, bytes_left_next;
  logic [14:0] held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  mode_t       access_kind, access_kind_next;
  logic [7:0]  last_read, last_read_next;
  logic        error_flag, error_flag_next;
  logic        done_next;

  logic [15:0] per;
  logic [16:0] uc_inc;
  logic        tick_hit;
  logic [15:0] ul_dec, uc_el, ul_el;
  logic        elapsed;
  logic        scl_o, sdo_o, en_o;
  logic [7:0]  ctrl_byte;
  logic [15:0] wait_units;
  logic [3:0]  bit_inc;

  // Unit timer, evaluated from the held counters
  always_comb begin
    per      = (cfg.unit_ticks == 16'd0) ? 16'd1 : cfg.unit_ticks;
    uc_inc   = {1'b0, unit_counter} + 17'd1;
    tick_hit = uc_inc >= {1'b0, per};
    ul_dec   = (units_left != 16'd0) ? units_left - 16'd1 : 16'd0;
    uc_el    = tick_hit ? 16'd0 : uc_inc[15:0];
    ul_el    = tick_hit ? ul_dec : units_left;
    elapsed  = tick_hit && (ul_dec == 16'd0);
    bit_inc  = bit_index + 4'd1;
  end

  // Control byte; block bits fold in for one-byte addressing
  always_comb begin
    ctrl_byte = {cfg.device_address, 1'b0};
    if (!cfg.two_byte_address) begin
      ctrl_byte[3:1] = ctrl_byte[3:1] | held_address[10:8];
    end
    ctrl_byte[0] = (stage == S_CTRL_R);
  end

  // Write cycle wait after the stop
  always_comb begin
    wait_units = 16'd0;
    if (!error_flag && access_kind == MODE_WRITE) wait_units = cfg.write_wait_units;
    if (!error_flag && access_kind == MODE_FILL)  wait_units = cfg.fill_wait_units;
  end

  // Line levels for the current phase
  always_comb begin
    scl_o = 1'b1;
    sdo_o = 1'b1;
    en_o  = 1'b1;
    unique case (phase)
      P_START_B: sdo_o = 1'b0;
      P_TX_LO1, P_TX_LO2: begin
        scl_o = 1'b0;
        sdo_o = shift_byte[7];
      end
      P_TX_HI: sdo_o = shift_byte[7];
      P_ACK_REL, P_RX_LO: begin
        scl_o = 1'b0;
        sdo_o = 1'b0;
        en_o  = 1'b0;
      end
      P_ACK_HI, P_ACK_POLL, P_RX_HI: begin
        sdo_o = 1'b0;
        en_o  = 1'b0;
      end
      P_NACK_LO: scl_o = 1'b0;
      P_STOP_A: begin
        scl_o = 1'b0;
        sdo_o = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_next        = phase;
    stage_next        = stage;
    unit_counter_next = unit_counter;
    units_left_next   = units_left;
    bit_index_next    = bit_index;
    shift_byte_next   = shift_byte;
    poll_counter_next = poll_counter;
    bytes_left_next   = bytes_left;
    held_address_next = held_address;
    held_data_next    = held_data;
    access_kind_next  = access_kind;
    last_read_next    = last_read;
    error_flag_next   = error_flag;
    done_next         = 1'b0;

    unique case (phase)
      P_IDLE: begin
        // command doubles as the first start tick
        if (mode != MODE_TICK) begin
          access_kind_next  = mode_t'(mode);
          held_address_next = mem_address & ADDR_MASK;
          held_data_next    = write_byte;
          error_flag_next   = 1'b0;
          poll_counter_next = 8'd0;
          bit_index_next    = 4'd0;
          bytes_left_next   = 7'd1;
          if (mode == MODE_FILL && cfg.fill_count != 7'd0) bytes_left_next = cfg.fill_count;
          stage_next        = S_CTRL_W;
          phase_next        = P_START_A;
          if (per == 16'd1) begin
            unit_counter_next = 16'd0;
            units_left_next   = 16'd3;
          end else begin
            unit_counter_next = 16'd1;
            units_left_next   = 16'd4;
          end
        end
      end
      P_START_A: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_START_B;
          units_left_next = 16'd4;
        end
      end
      P_START_B: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          shift_byte_next = ctrl_byte;
          bit_index_next  = 4'd0;
          phase_next      = P_TX_LO1;
          units_left_next = 16'd2;
        end
      end
      P_TX_LO1: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_TX_HI;
          units_left_next = 16'd2;
        end
      end
      P_TX_HI: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_TX_LO2;
          units_left_next = 16'd2;
        end
      end
      P_TX_LO2: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            bit_index_next  = 4'd0;
            phase_next      = P_ACK_REL;
            units_left_next = 16'd1;
          end else begin
            bit_index_next  = bit_inc;
            phase_next      = P_TX_LO1;
            units_left_next = 16'd2;
          end
        end
      end
      P_ACK_REL: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_ACK_HI;
          units_left_next = 16'd2;
        end
      end
      P_ACK_HI: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          poll_counter_next = 8'd0;
          phase_next        = P_ACK_POLL;
          units_left_next   = 16'd0;
        end
      end
      P_ACK_POLL: begin
        if (!sda_sample) begin
          // acknowledged: move on to the next part of the frame
          poll_counter_next = 8'd0;
          unit_counter_next = 16'd0;
          unique case (stage)
            S_CTRL_W: begin
              bit_index_next  = 4'd0;
              phase_next      = P_TX_LO1;
              units_left_next = 16'd2;
              if (cfg.two_byte_address) begin
                stage_next      = S_ADDR_HI;
                shift_byte_next = {1'b0, held_address[14:8]};
              end else begin
                stage_next      = S_ADDR_LO;
                shift_byte_next = held_address[7:0];
              end
            end
            S_ADDR_HI: begin
              stage_next      = S_ADDR_LO;
              shift_byte_next = held_address[7:0];
              bit_index_next  = 4'd0;
              phase_next      = P_TX_LO1;
              units_left_next = 16'd2;
            end
            S_ADDR_LO: begin
              if (access_kind == MODE_READ) begin
                stage_next      = S_CTRL_R;
                phase_next      = P_START_A;
                units_left_next = 16'd4;
              end else begin
                stage_next      = S_DATA;
                shift_byte_next = held_data;
                bit_index_next  = 4'd0;
                phase_next      = P_TX_LO1;
                units_left_next = 16'd2;
              end
            end
            S_DATA: begin
              if (bytes_left > 7'd1) begin
                bytes_left_next = bytes_left - 7'd1;
                shift_byte_next = held_data;
                bit_index_next  = 4'd0;
                phase_next      = P_TX_LO1;
                units_left_next = 16'd2;
              end else begin
                bytes_left_next = 7'd0;
                phase_next      = P_STOP_A;
                units_left_next = 16'd4;
              end
            end
            default: begin
              // after the read control byte
              bit_index_next  = 4'd0;
              shift_byte_next = 8'd0;
              phase_next      = P_RX_LO;
              units_left_next = 16'd2;
            end
          endcase
        end else if (poll_counter >= cfg.ack_poll_limit) begin
          // no acknowledge: stop and flag
          poll_counter_next = 8'd0;
          error_flag_next   = 1'b1;
          phase_next        = P_STOP_A;
          units_left_next   = 16'd4;
          unit_counter_next = 16'd0;
        end else begin
          poll_counter_next = poll_counter + 8'd1;
        end
      end
      P_RX_LO: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_RX_HI;
          units_left_next = 16'd1;
        end
      end
      P_RX_HI: begin
        // sample on the first high tick
        if (unit_counter == 16'd0 && units_left == 16'd1) begin
          shift_byte_next = {shift_byte[6:0], sda_sample};
        end
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          if (bit_inc >= 4'd8) begin
            bit_index_next  = 4'd0;
            last_read_next  = shift_byte_next;
            phase_next      = P_NACK_LO;
            units_left_next = 16'd2;
          end else begin
            bit_index_next  = bit_inc;
            phase_next      = P_RX_LO;
            units_left_next = 16'd2;
          end
        end
      end
      P_NACK_LO: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_NACK_HI;
          units_left_next = 16'd2;
        end
      end
      P_NACK_HI: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_STOP_A;
          units_left_next = 16'd4;
        end
      end
      P_STOP_A: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_STOP_B;
          units_left_next = 16'd4;
        end
      end
      P_STOP_B: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          if (wait_units != 16'd0) begin
            phase_next      = P_WAIT;
            units_left_next = wait_units;
          end else begin
            phase_next      = P_IDLE;
            units_left_next = 16'd0;
            done_next       = 1'b1;
          end
        end
      end
      P_WAIT: begin
        unit_counter_next = uc_el;
        units_left_next   = ul_el;
        if (elapsed) begin
          phase_next      = P_IDLE;
          units_left_next = 16'd0;
          done_next       = 1'b1;
        end
      end
    endcase
  end

  // Result of this transaction
  always_comb begin
    res.scl_level   = scl_o;
    res.sda_level   = sdo_o;
    res.sda_enable  = en_o;
    res.busy_res    = (phase_next != P_IDLE);
    res.done_res    = done_next;
    res.read_result = last_read_next;
    res.ack_error   = error_flag_next;
  end

  // State registers, advanced once per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_IDLE;
      stage        <= S_CTRL_W;
      unit_counter <= 16'd0;
      units_left   <= 16'd0;
      bit_index    <= 4'd0;
      shift_byte   <= 8'd0;
      poll_counter <= 8'd0;
      bytes_left   <= 7'd0;
      held_address <= 15'd0;
      held_data    <= 8'd0;
      access_kind  <= MODE_TICK;
      last_read    <= 8'd0;
      error_flag   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      stage        <= stage_next;
      unit_counter <= unit_counter_next;
      units_left   <= units_left_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      poll_counter <= poll_counter_next;
      bytes_left   <= bytes_left_next;
      held_address <= held_address_next;
      held_data    <= held_data_next;
      access_kind  <= access_kind_next;
      last_read    <= last_read_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2cee_out_buf.sv
// Result register with a skid entry between sequencer and output channel.
// Depends on i2cee_pkg.
`default_nettype none

module i2cee_out_buf
  import i2cee_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t res_in,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      res_out
);

  logic main_valid, skid_valid;
  res_t main_q, skid_q;
  logic take;

  assign take      = main_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign res_out   = main_q;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        main_q <= skid_q;
      end else if (push) begin
        main_q <= res_in;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_q <= res_in;
      end else begin
        main_q <= res_in;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_eeprom_byte_access_core.sv
// I2C EEPROM byte access core, top level; uses i2cee_pkg and its submodules.
// A transaction's result is registered in the output buffer when it is accepted, behind any result still held there.
// Throughput: one transaction per cycle while in_stall is low; the sequencer steps once per accepted transaction.
// A two-entry result buffer lets one more transaction be accepted while the output is stalled.
// Reset (synchronous) idles the sequencer, empties the buffer, reloads registers.
`default_nettype none

module i2c_eeprom_byte_access_core
  import i2cee_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [14:0]        mem_address,
  input  wire logic [7:0]         write_byte,
  input  wire logic               sda_sample,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    scl_level,
  output logic                    sda_level,
  output logic                    sda_enable,
  output logic                    busy_res,
  output logic                    done_res,
  output logic [7:0]              read_result,
  output logic                    ack_error
);

  cfg_t cfg;
  res_t seq_res, out_res;
  logic accept;

  assign accept = in_valid && !in_stall;

  i2cee_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2cee_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .mode        (mode),
    .mem_address (mem_address),
    .write_byte  (write_byte),
    .sda_sample  (sda_sample),
    .res         (seq_res)
  );

  i2cee_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .res_in    (seq_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (out_res)
  );

  assign scl_level   = out_res.scl_level;
  assign sda_level   = out_res.sda_level;
  assign sda_enable  = out_res.sda_enable;
  assign busy_res    = out_res.busy_res;
  assign done_res    = out_res.done_res;
  assign read_result = out_res.read_result;
  assign ack_error   = out_res.ack_error;

endmodule

`default_nettype wire

>>> hw/rtl/i2cee_checker.sv
// Port-level checks of the I2C EEPROM byte access core, bound to the top.
// Uses the assertion macros of i2c_eeprom_byte_access_core_defines.svh.
`default_nettype none

`include "i2c_eeprom_byte_access_core_defines.svh"

module i2cee_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       scl_level,
  input wire logic       sda_level,
  input wire logic       sda_enable,
  input wire logic       busy_res,
  input wire logic       done_res,
  input wire logic [7:0] read_result,
  input wire logic       ack_error
);

  // stalled result holds
  `I2CEE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable({scl_level, sda_level, sda_enable, busy_res, done_res,
    read_result, ack_error}), "stalled result changed")

  // every accepted transaction yields a pending result
  `I2CEE_ASSERT_NEXT(a_accept_result, in_valid && !in_stall, out_valid,
    "accepted transaction left no result")

  // a transaction landing behind a stalled result fills the skid entry
  `I2CEE_ASSERT_NEXT(a_skid_fill, out_valid && out_stall && in_valid && !in_stall,
    in_stall, "skid entry not marked full")

  // released SDA is reported low
  `I2CEE_ASSERT_NOW(a_sda_release, out_valid && !sda_enable, !sda_level,
    "sda_level high while released")

  // the finishing tick is no longer busy
  `I2CEE_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res,
    "done reported while still busy")

endmodule

bind i2c_eeprom_byte_access_core i2cee_checker u_i2cee_checker (.*);

`default_nettype wire
